// ===== rtl/core/bcdc_pkg.sv =====
// Shared types and constants of the blocked causal dynamic convolution.
package bcdc_pkg;

  localparam int CH_W    = 12;
  localparam int POS_W   = 12;
  localparam int VAL_W   = 16;
  localparam int TAP_W   = 2;
  localparam int COEF_W  = 17;
  localparam int PROD_W  = COEF_W + VAL_W;
  localparam int CFG_W   = 13;
  localparam int FRAC_W  = 13;
  localparam int DELTA_N = 4;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic [CFG_W-1:0] POS_LIMIT  = 13'd4096;
  localparam logic [CFG_W-1:0] BLK_RESET  = 13'd16;
  localparam logic [2:0]       TAPS_RESET = 3'd4;
  localparam int               ROUND_HALF = 4096;

  typedef enum logic [0:0] {
    CFG_BLOCK_SIZE = 1'b0,
    CFG_TAPS       = 1'b1
  } bcdc_cfg_idx_t;

  typedef struct packed {
    logic [CH_W-1:0]  ch;
    logic [POS_W-1:0] pos;
  } bcdc_tag_t;

  typedef struct packed {
    logic      vld;
    bcdc_tag_t tag;
  } bcdc_ctl_t;

endpackage

// ===== rtl/core/bcdc_in_if.sv =====
// Input channel: coefficient loads and data samples.
interface bcdc_in_if import bcdc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    cmd;
  logic [CH_W-1:0]         channel;
  logic [TAP_W-1:0]        tap_index;
  logic signed [VAL_W-1:0] value;
  logic signed [VAL_W-1:0] delta_0;
  logic signed [VAL_W-1:0] delta_1;
  logic signed [VAL_W-1:0] delta_2;
  logic signed [VAL_W-1:0] delta_3;

  modport source (output valid, cmd, channel, tap_index, value,
                  delta_0, delta_1, delta_2, delta_3, input ready);
  modport sink   (input valid, cmd, channel, tap_index, value,
                  delta_0, delta_1, delta_2, delta_3, output ready);
endinterface

// ===== rtl/core/bcdc_out_if.sv =====
// Result channel: one convolved element per data sample.
interface bcdc_out_if import bcdc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CH_W-1:0]         out_channel;
  logic signed [VAL_W-1:0] out_value;
  logic                    out_saturated;
  logic [POS_W-1:0]        out_position;

  modport source (output valid, out_channel, out_value, out_saturated, out_position,
                  input ready);
  modport sink   (input valid, out_channel, out_value, out_saturated, out_position,
                  output ready);
endinterface

// ===== rtl/core/bcdc_store.sv =====
// First stage: coefficient and history memories, write forwarding and block position.
module bcdc_store import bcdc_pkg::*; #(
  parameter int CHANNELS = 4096,
  parameter int TAPS_MAX = 4,
  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
  localparam int HN = (TAPS_MAX > 1) ? TAPS_MAX - 1 : 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    in_take,
  input  logic                    in_cmd,
  input  logic [CH_W-1:0]         in_channel,
  input  logic [TAP_W-1:0]        in_tap,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic signed [VAL_W-1:0] in_delta [DELTA_N],
  input  logic [CFG_W-1:0]        blk_len,
  output bcdc_ctl_t               s1,
  output logic signed [VAL_W-1:0] s1_x,
  output logic signed [VAL_W-1:0] s1_delta [DELTA_N],
  output logic signed [VAL_W-1:0] s1_base [TAPS_MAX],
  output logic signed [VAL_W-1:0] s1_hist [HN]
);

  localparam logic [14:0] CH_LIM  = 15'(CHANNELS);
  localparam logic [14:0] CH_LAST = 15'(CHANNELS - 1);

  logic [14:0]   ch_ext;
  logic          in_range;
  logic [AW-1:0] rd_addr;

  logic                    s1_vld_r;
  logic                    s1_cmd_r;
  logic [TAP_W-1:0]        s1_tap_r;
  logic [CH_W-1:0]         s1_ch_r;
  logic [AW-1:0]           s1_addr_r;
  logic signed [VAL_W-1:0] s1_val_r;
  logic signed [VAL_W-1:0] s1_delta_r [DELTA_N];

  logic s1_go;
  logic is_load;
  logic is_smp;
  logic tap_ok;

  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_nxt;
  logic [CFG_W-1:0] blk_eff;
  logic [CFG_W-1:0] pos_inc;

  logic signed [VAL_W-1:0] base_q [TAPS_MAX];
  logic signed [VAL_W-1:0] hist_q [HN];

  assign ch_ext   = {3'b000, in_channel};
  assign in_range = ch_ext < CH_LIM;
  assign rd_addr  = ch_ext[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_take && in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cmd_r   <= in_cmd;
      s1_tap_r   <= in_tap;
      s1_ch_r    <= in_channel;
      s1_addr_r  <= rd_addr;
      s1_val_r   <= in_value;
      s1_delta_r <= in_delta;
    end
  end

  // Memories are written as a transaction leaves this stage; the one entering at the
  // same edge takes the new word through the bypass below.
  assign s1_go   = adv && s1_vld_r;
  assign is_load = s1_cmd_r == CMD_LOAD;
  assign is_smp  = s1_cmd_r == CMD_SAMPLE;
  assign tap_ok  = 4'(s1_tap_r) < 4'(TAPS_MAX);

  for (genvar t = 0; t < TAPS_MAX; t++) begin : g_base
    logic [VAL_W-1:0] mem [CHANNELS];
    logic [VAL_W-1:0] rd_r;
    logic             we;

    assign we = s1_go && is_load && tap_ok && (4'(s1_tap_r) == 4'(t));

    always_ff @(posedge clk) begin
      if (we) begin
        mem[s1_addr_r] <= s1_val_r;
      end
      if (adv) begin
        if (we && (s1_addr_r == rd_addr)) begin
          rd_r <= s1_val_r;
        end else begin
          rd_r <= mem[rd_addr];
        end
      end
    end

    assign base_q[t] = $signed(rd_r);
  end

  if (TAPS_MAX > 1) begin : g_hist_on
    for (genvar k = 0; k < TAPS_MAX - 1; k++) begin : g_hist
      logic [VAL_W-1:0] mem [CHANNELS];
      logic [VAL_W-1:0] rd_r;
      logic [VAL_W-1:0] wdata;
      logic             we;

      // Each sample shifts the channel's history by one token.
      if (k == 0) begin : g_first
        assign wdata = s1_val_r;
      end else begin : g_next
        assign wdata = hist_q[k-1];
      end

      assign we = s1_go && is_smp;

      always_ff @(posedge clk) begin
        if (we) begin
          mem[s1_addr_r] <= wdata;
        end
        if (adv) begin
          if (we && (s1_addr_r == rd_addr)) begin
            rd_r <= wdata;
          end else begin
            rd_r <= mem[rd_addr];
          end
        end
      end

      assign hist_q[k] = $signed(rd_r);
    end
  end else begin : g_hist_off
    assign hist_q[0] = '0;
  end

  always_comb begin
    if (blk_len == '0) begin
      blk_eff = 13'd1;
    end else if (blk_len > POS_LIMIT) begin
      blk_eff = POS_LIMIT;
    end else begin
      blk_eff = blk_len;
    end
    pos_inc = {1'b0, pos_r} + 13'd1;
    pos_nxt = (pos_inc >= blk_eff) ? '0 : pos_inc[POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (s1_go && is_smp && ({3'b000, s1_ch_r} == CH_LAST)) begin
      pos_r <= pos_nxt;
    end
  end

  assign s1.vld     = s1_vld_r && is_smp;
  assign s1.tag.ch  = s1_ch_r;
  assign s1.tag.pos = pos_r;
  assign s1_x       = s1_val_r;
  assign s1_delta   = s1_delta_r;
  assign s1_base    = base_q;
  assign s1_hist    = hist_q;

endmodule

// ===== rtl/core/bcdc_mac.sv =====
// Coefficient add, per-tap multiply and tap sum, one register stage each.
module bcdc_mac import bcdc_pkg::*; #(
  parameter int TAPS_MAX = 4,
  localparam int HN    = (TAPS_MAX > 1) ? TAPS_MAX - 1 : 1,
  localparam int TW    = $clog2(TAPS_MAX + 1),
  localparam int SUM_W = PROD_W + $clog2(TAPS_MAX)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  bcdc_ctl_t               s1,
  input  logic signed [VAL_W-1:0] s1_x,
  input  logic signed [VAL_W-1:0] s1_delta [DELTA_N],
  input  logic signed [VAL_W-1:0] s1_base [TAPS_MAX],
  input  logic signed [VAL_W-1:0] s1_hist [HN],
  input  logic [TW-1:0]           taps_eff,
  output bcdc_ctl_t               s4,
  output logic signed [SUM_W-1:0] s4_sum
);

  logic signed [COEF_W-1:0] c_nxt  [TAPS_MAX];
  logic signed [VAL_W-1:0]  xs_nxt [TAPS_MAX];

  logic                     vld2_r, vld3_r, vld4_r;
  bcdc_tag_t                tag2_r, tag3_r, tag4_r;
  logic signed [COEF_W-1:0] c_r  [TAPS_MAX];
  logic signed [VAL_W-1:0]  xs_r [TAPS_MAX];
  logic signed [PROD_W-1:0] p_r  [TAPS_MAX];
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [SUM_W-1:0]  sum_nxt;

  for (genvar k = 0; k < TAPS_MAX; k++) begin : g_tap
    logic                    en;
    logic signed [VAL_W-1:0] dk;

    // A tap reaches back only as far as the current block allows. A disabled tap
    // forces both operands to zero, so history it never needs cannot reach the sum.
    assign en = (taps_eff > TW'(k)) && (s1.tag.pos >= POS_W'(k));

    if (k < DELTA_N) begin : g_delta
      assign dk = s1_delta[k];
    end else begin : g_nodelta
      assign dk = '0;
    end

    if (k == 0) begin : g_cur
      assign xs_nxt[k] = en ? s1_x : '0;
    end else begin : g_past
      assign xs_nxt[k] = en ? s1_hist[k-1] : '0;
    end

    assign c_nxt[k] = en ? (COEF_W'(s1_base[k]) + COEF_W'(dk)) : '0;
  end

  always_comb begin
    sum_nxt = '0;
    for (int k = 0; k < TAPS_MAX; k++) begin
      sum_nxt = sum_nxt + SUM_W'(p_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else if (adv) begin
      vld2_r <= s1.vld;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag2_r <= s1.tag;
      tag3_r <= tag2_r;
      tag4_r <= tag3_r;
      c_r    <= c_nxt;
      xs_r   <= xs_nxt;
      for (int k = 0; k < TAPS_MAX; k++) begin
        p_r[k] <= PROD_W'(c_r[k]) * PROD_W'(xs_r[k]);
      end
      sum_r  <= sum_nxt;
    end
  end

  assign s4.vld = vld4_r;
  assign s4.tag = tag4_r;
  assign s4_sum = sum_r;

endmodule

// ===== rtl/core/bcdc_round.sv =====
// Output stage: round half up to Q2.13, saturate to 16 bits and hold the result.
module bcdc_round import bcdc_pkg::*; #(
  parameter int SUM_W = 35,
  localparam int QW = SUM_W + 1 - FRAC_W
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  bcdc_ctl_t               s4,
  input  logic signed [SUM_W-1:0] s4_sum,
  output logic                    out_vld,
  output logic [CH_W-1:0]         out_channel,
  output logic signed [VAL_W-1:0] out_value,
  output logic                    out_saturated,
  output logic [POS_W-1:0]        out_position
);

  logic signed [SUM_W:0]   biased;
  logic [QW-1:0]           q;
  logic                    sat_hi;
  logic                    sat_lo;
  logic signed [VAL_W-1:0] val_nxt;

  logic                    vld_r;
  logic [CH_W-1:0]         ch_r;
  logic signed [VAL_W-1:0] val_r;
  logic                    sat_r;
  logic [POS_W-1:0]        pos_r;

  // Dropping the fraction bits of the biased sum is the floor division.
  assign biased = (SUM_W+1)'(s4_sum) + (SUM_W+1)'(ROUND_HALF);
  assign q      = biased[SUM_W:FRAC_W];
  assign sat_hi = !q[QW-1] && (|q[QW-2:VAL_W-1]);
  assign sat_lo = q[QW-1] && !(&q[QW-2:VAL_W-1]);

  always_comb begin
    if (sat_hi) begin
      val_nxt = 16'sh7fff;
    end else if (sat_lo) begin
      val_nxt = -16'sh8000;
    end else begin
      val_nxt = $signed(q[VAL_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= s4.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ch_r  <= s4.tag.ch;
      pos_r <= s4.tag.pos;
      val_r <= val_nxt;
      sat_r <= sat_hi || sat_lo;
    end
  end

  assign out_vld       = vld_r;
  assign out_channel   = ch_r;
  assign out_value     = val_r;
  assign out_saturated = sat_r;
  assign out_position  = pos_r;

endmodule

// ===== rtl/core/blocked_causal_dynamic_conv.sv =====
// Top level of the blocked causal dynamic convolution.
// A per-channel causal convolution over a token stream: coefficient loads (cmd 0) fill
// the base store and produce no result, data samples (cmd 1) each produce one result.
// One transaction is taken in every cycle unless the whole pipeline holds because a
// result waits to be taken; a sample passes five register stages (memory read,
// coefficient add, multiply, tap sum, round and saturate). The coefficient and history
// memories have no reset and need no clearing pass; only the valid flags, the block
// position and the two configuration registers are cleared. Items with a channel at
// or above CHANNELS are dropped without effect.
module blocked_causal_dynamic_conv import bcdc_pkg::*; #(
  parameter int CHANNELS = 4096,
  parameter int TAPS_MAX = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  bcdc_in_if.sink          in_ch,
  bcdc_out_if.source       out_ch,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int HN    = (TAPS_MAX > 1) ? TAPS_MAX - 1 : 1;
  localparam int TW    = $clog2(TAPS_MAX + 1);
  localparam int SUM_W = PROD_W + $clog2(TAPS_MAX);

  logic [CFG_W-1:0] blk_size_r;
  logic [2:0]       taps_r;
  logic [TW-1:0]    taps_eff;

  logic                    adv;
  logic                    out_vld;
  logic signed [VAL_W-1:0] in_delta [DELTA_N];

  bcdc_ctl_t               s1;
  logic signed [VAL_W-1:0] s1_x;
  logic signed [VAL_W-1:0] s1_delta [DELTA_N];
  logic signed [VAL_W-1:0] s1_base [TAPS_MAX];
  logic signed [VAL_W-1:0] s1_hist [HN];
  bcdc_ctl_t               s4;
  logic signed [SUM_W-1:0] s4_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_size_r <= BLK_RESET;
      taps_r     <= TAPS_RESET;
    end else if (cfg_we) begin
      unique case (bcdc_cfg_idx_t'(cfg_index))
        CFG_BLOCK_SIZE: blk_size_r <= cfg_wdata;
        CFG_TAPS:       taps_r     <= cfg_wdata[2:0];
      endcase
    end
  end

  always_comb begin
    if (taps_r == '0) begin
      taps_eff = TW'(1);
    end else if (4'(taps_r) > 4'(TAPS_MAX)) begin
      taps_eff = TW'(TAPS_MAX);
    end else begin
      taps_eff = TW'(taps_r);
    end
  end

  // Every stage moves together; a waiting result freezes the whole pipeline.
  assign adv         = !out_vld || out_ch.ready;
  assign in_ch.ready = adv;
  assign out_ch.valid = out_vld;

  assign in_delta[0] = in_ch.delta_0;
  assign in_delta[1] = in_ch.delta_1;
  assign in_delta[2] = in_ch.delta_2;
  assign in_delta[3] = in_ch.delta_3;

  bcdc_store #(
    .CHANNELS (CHANNELS),
    .TAPS_MAX (TAPS_MAX)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_take    (in_ch.valid),
    .in_cmd     (in_ch.cmd),
    .in_channel (in_ch.channel),
    .in_tap     (in_ch.tap_index),
    .in_value   (in_ch.value),
    .in_delta   (in_delta),
    .blk_len    (blk_size_r),
    .s1         (s1),
    .s1_x       (s1_x),
    .s1_delta   (s1_delta),
    .s1_base    (s1_base),
    .s1_hist    (s1_hist)
  );

  bcdc_mac #(
    .TAPS_MAX (TAPS_MAX)
  ) u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .s1       (s1),
    .s1_x     (s1_x),
    .s1_delta (s1_delta),
    .s1_base  (s1_base),
    .s1_hist  (s1_hist),
    .taps_eff (taps_eff),
    .s4       (s4),
    .s4_sum   (s4_sum)
  );

  bcdc_round #(
    .SUM_W (SUM_W)
  ) u_round (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .s4            (s4),
    .s4_sum        (s4_sum),
    .out_vld       (out_vld),
    .out_channel   (out_ch.out_channel),
    .out_value     (out_ch.out_value),
    .out_saturated (out_ch.out_saturated),
    .out_position  (out_ch.out_position)
  );

`ifndef NO_ASSERTIONS
  a_sat_clamps: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.out_saturated |->
      (out_ch.out_value == 16'sh7fff) || (out_ch.out_value == -16'sh8000))
    else $error("saturated result not at a range limit");

  a_taps_range: assert property (@(posedge clk) disable iff (!rst_n)
    (taps_eff != '0) && (taps_eff <= TW'(TAPS_MAX)))
    else $error("effective tap count out of range");

  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_ch.valid)
    else $error("result valid straight after reset");
`endif

endmodule

// ===== tb/tb_blocked_causal_dynamic_conv.sv =====
// Self-checking testbench of the blocked causal dynamic convolution top level.
module tb_blocked_causal_dynamic_conv;
  import bcdc_pkg::*;

  localparam int NUM_CH       = 4096;
  localparam int NUM_TAPS     = 4;
  localparam int PIPE_DEPTH   = 5;
  localparam int RANDOM_ITEMS = 1270;
  localparam int SWEEP_PHASES = 11;
  localparam int CYCLE_LIMIT  = 400000;

  localparam logic [CH_W-1:0] POOL_CH [8] = '{12'h000, 12'h555, 12'hAAA, 12'hFFF,
                                              12'h001, 12'h7FF, 12'h800, 12'hFFE};
  localparam logic [CFG_W-1:0] SWEEP_BLK [SWEEP_PHASES-1] = '{13'd16, 13'd1, 13'd0,
    13'd3, 13'd2, 13'd5, 13'd4096, 13'd8191, 13'd7, 13'd4};
  localparam logic [2:0] SWEEP_TAPS [SWEEP_PHASES-1] = '{3'd4, 3'd4, 3'd2, 3'd0, 3'd7,
    3'd3, 3'd4, 3'd5, 3'd1, 3'd2};

  typedef struct packed {
    logic                          cmd;
    logic [CH_W-1:0]               ch;
    logic [TAP_W-1:0]              tap;
    logic [VAL_W-1:0]              value;
    logic [DELTA_N-1:0][VAL_W-1:0] delta;
  } conv_item_t;

  typedef struct packed {
    logic [CH_W-1:0]  ch;
    logic [VAL_W-1:0] value;
    logic             sat;
    logic [POS_W-1:0] pos;
  } conv_result_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [0:0]       cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  bcdc_in_if  in_ch ();
  bcdc_out_if out_ch ();

  blocked_causal_dynamic_conv #(
    .CHANNELS (NUM_CH),
    .TAPS_MAX (NUM_TAPS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow state of the convolution.
  logic [VAL_W-1:0] coef_mem     [NUM_TAPS][NUM_CH];
  logic [VAL_W-1:0] hist_mem     [NUM_TAPS-1][NUM_CH];
  bit               coef_written [NUM_TAPS][NUM_CH];
  bit               hist_written [NUM_TAPS-1][NUM_CH];
  int unsigned      token_pos;
  logic [CFG_W-1:0] blk_setting;
  logic [2:0]       taps_setting;
  conv_result_t     conv_pending_q [$];

  int unsigned fail_count   = 0;
  int unsigned cycle_count  = 0;
  int unsigned burst_left   = 0;
  int unsigned n_loads      = 0;
  int unsigned n_samples    = 0;
  int unsigned n_saturated  = 0;
  int unsigned n_cfg_writes = 0;
  int unsigned max_pos      = 0;
  int unsigned ready_mode   = 0;
  int unsigned ready_span   = 0;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("blocked_causal_dynamic_conv: mismatch");
      $finish;
    end
  end

  // The receiver picks a new stall behaviour each time its random span runs out.
  always @(posedge clk) begin
    if (ready_span == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_span = $urandom_range(16, 200);
    end else begin
      ready_span--;
    end
    case (ready_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 1) == 0);
      2: out_ch.ready <= ($urandom_range(0, 7) != 0);
      default: out_ch.ready <= ((ready_span % 12) >= 4);
    endcase
  end

  always @(posedge clk) begin : check_results
    conv_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (conv_pending_q.size() == 0) begin
        $error("result on channel %0d with no transaction pending", out_ch.out_channel);
        fail_count++;
      end else begin
        exp_r = conv_pending_q.pop_front();
        if (out_ch.out_channel !== exp_r.ch) begin
          $error("out_channel: expected %0d, actual %0d", exp_r.ch, out_ch.out_channel);
          fail_count++;
        end
        if (out_ch.out_value !== exp_r.value) begin
          $error("out_value: expected %0d, actual %0d", $signed(exp_r.value),
                 $signed(out_ch.out_value));
          fail_count++;
        end
        if (out_ch.out_saturated !== exp_r.sat) begin
          $error("out_saturated: expected %0d, actual %0d", exp_r.sat,
                 out_ch.out_saturated);
          fail_count++;
        end
        if (out_ch.out_position !== exp_r.pos) begin
          $error("out_position: expected %0d, actual %0d", exp_r.pos, out_ch.out_position);
          fail_count++;
        end
      end
    end
  end

  function automatic int unsigned taps_active();
    if (taps_setting == 3'd0) return 1;
    if (taps_setting > NUM_TAPS) return NUM_TAPS;
    return 32'(taps_setting);
  endfunction

  // True when a sample on this channel would only read entries already written.
  function automatic bit operands_known(logic [CH_W-1:0] ch);
    int unsigned k;
    for (k = 0; k < taps_active(); k++) begin
      if (k <= token_pos) begin
        if (!coef_written[k][ch]) return 1'b0;
        if (k > 0 && !hist_written[k-1][ch]) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic conv_apply(conv_item_t item);
    longint       acc;
    longint       coef;
    longint       xs;
    longint       q;
    int unsigned  k;
    int           h;
    int unsigned  blk;
    conv_result_t r;
    if (item.cmd == CMD_LOAD) begin
      coef_mem[item.tap][item.ch]     = item.value;
      coef_written[item.tap][item.ch] = 1'b1;
      n_loads++;
      return;
    end
    acc = 0;
    for (k = 0; k < taps_active(); k++) begin
      if (k <= token_pos) begin
        coef = longint'($signed(coef_mem[k][item.ch])) + longint'($signed(item.delta[k]));
        if (k == 0) xs = longint'($signed(item.value));
        else xs = longint'($signed(hist_mem[k-1][item.ch]));
        acc += coef * xs;
      end
    end
    q = (acc + ROUND_HALF) >>> FRAC_W;
    if (q > 32767) begin
      q     = 32767;
      r.sat = 1'b1;
    end else if (q < -32768) begin
      q     = -32768;
      r.sat = 1'b1;
    end else begin
      r.sat = 1'b0;
    end
    r.ch    = item.ch;
    r.value = VAL_W'(q);
    r.pos   = POS_W'(token_pos);
    conv_pending_q.push_back(r);
    n_samples++;
    if (r.sat) n_saturated++;
    if (token_pos > max_pos) max_pos = token_pos;
    for (h = NUM_TAPS - 2; h >= 1; h--) begin
      hist_mem[h][item.ch]     = hist_mem[h-1][item.ch];
      hist_written[h][item.ch] = hist_written[h-1][item.ch];
    end
    hist_mem[0][item.ch]     = item.value;
    hist_written[0][item.ch] = 1'b1;
    if (item.ch == CH_W'(NUM_CH - 1)) begin
      blk = 32'(blk_setting);
      if (blk == 0) blk = 1;
      if (blk > POS_LIMIT) blk = POS_LIMIT;
      token_pos++;
      if (token_pos >= blk) token_pos = 0;
    end
  endtask

  // Drives one item; the start of a burst may bring an idle gap.
  task automatic send_item(conv_item_t item);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_ch.cmd       <= item.cmd;
    in_ch.channel   <= item.ch;
    in_ch.tap_index <= item.tap;
    in_ch.value     <= item.value;
    in_ch.delta_0   <= item.delta[0];
    in_ch.delta_1   <= item.delta[1];
    in_ch.delta_2   <= item.delta[2];
    in_ch.delta_3   <= item.delta[3];
    in_ch.valid     <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    conv_apply(item);
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (conv_pending_q.size() != 0) @(posedge clk);
  endtask

  // Loads leave no result behind, so waiting out the pipeline depth lets it empty.
  task automatic wait_idle();
    wait_for_results();
    repeat (PIPE_DEPTH + 4) @(posedge clk);
  endtask

  task automatic write_cfg(bcdc_cfg_idx_t idx, logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_BLOCK_SIZE) blk_setting = data;
    else taps_setting = data[2:0];
    n_cfg_writes++;
    @(posedge clk);
  endtask

  function automatic conv_item_t make_item(logic cmd, logic [CH_W-1:0] ch,
                                           logic [TAP_W-1:0] tap, logic [VAL_W-1:0] value,
                                           logic [VAL_W-1:0] delta);
    conv_item_t item;
    item.cmd   = cmd;
    item.ch    = ch;
    item.tap   = tap;
    item.value = value;
    item.delta = {DELTA_N{delta}};
    return item;
  endfunction

  function automatic logic [VAL_W-1:0] rand_q();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return VAL_W'($urandom_range(0, 65535));
    if (pick == 4) return ($urandom_range(0, 1) == 0) ? 16'h7FFF : 16'h8000;
    // Small magnitudes, -4096 to 4095, keep most sums clear of saturation.
    return VAL_W'($urandom_range(0, 8191) + 61440);
  endfunction

  function automatic conv_item_t random_item();
    conv_item_t  item;
    int unsigned r;
    int unsigned k;
    item.cmd   = ($urandom_range(0, 99) < 10) ? CMD_LOAD : CMD_SAMPLE;
    item.tap   = TAP_W'($urandom_range(0, 3));
    item.value = rand_q();
    for (k = 0; k < DELTA_N; k++) item.delta[k] = rand_q();
    r = $urandom_range(0, 99);
    if (r < 30) item.ch = CH_W'(NUM_CH - 1);
    else if (r < 85) item.ch = POOL_CH[$urandom_range(0, 7)];
    else item.ch = CH_W'($urandom_range(0, NUM_CH - 1));
    if (item.cmd == CMD_SAMPLE && !operands_known(item.ch))
      item.ch = POOL_CH[$urandom_range(0, 7)];
    return item;
  endfunction

  task automatic test_load_coefficients();
    int unsigned c;
    int unsigned k;
    for (c = 0; c < 8; c++)
      for (k = 0; k < NUM_TAPS; k++)
        send_item(make_item(CMD_LOAD, POOL_CH[c], TAP_W'(k), rand_q(), 16'h0000));
  endtask

  // Three samples per channel at block position zero fill the whole history.
  // The last channel is left out here, since its samples advance the position.
  task automatic test_prime_history();
    int unsigned c;
    int unsigned n;
    for (c = 0; c < 8; c++)
      if (POOL_CH[c] != CH_W'(NUM_CH - 1))
        for (n = 0; n < NUM_TAPS - 1; n++)
          send_item(make_item(CMD_SAMPLE, POOL_CH[c], TAP_W'(n), rand_q(), rand_q()));
  endtask

  task automatic test_corner_values();
    int unsigned k;
    for (k = 0; k < NUM_TAPS; k++) begin
      send_item(make_item(CMD_LOAD, 12'h000, TAP_W'(k), 16'h7FFF, 16'h0000));
      send_item(make_item(CMD_LOAD, 12'hAAA, TAP_W'(k), 16'h8000, 16'h0000));
    end
    // Move the block position up to three so that every tap takes part.
    send_item(make_item(CMD_SAMPLE, 12'hFFF, 2'd3, 16'h7FFF, 16'h7FFF));
    send_item(make_item(CMD_SAMPLE, 12'hFFF, 2'd0, 16'h8000, 16'h8000));
    send_item(make_item(CMD_SAMPLE, 12'hFFF, 2'd1, 16'h0000, 16'h0000));
    send_item(make_item(CMD_SAMPLE, 12'h000, 2'd3, 16'h7FFF, 16'h7FFF));
    send_item(make_item(CMD_SAMPLE, 12'hAAA, 2'd0, 16'h7FFF, 16'h8000));
    send_item(make_item(CMD_SAMPLE, 12'hAAA, 2'd2, 16'h8000, 16'h8000));
    send_item(make_item(CMD_SAMPLE, 12'h000, 2'd1, 16'h0000, 16'h0000));
    send_item(make_item(CMD_SAMPLE, 12'h555, 2'd3, 16'h8000, 16'h7FFF));
  endtask

  // Single tap with a coefficient of one LSB exposes the half-up rounding.
  task automatic test_rounding();
    wait_idle();
    write_cfg(CFG_TAPS, 13'd1);
    send_item(make_item(CMD_LOAD, 12'h001, 2'd0, 16'h0001, 16'h0000));
    send_item(make_item(CMD_SAMPLE, 12'h001, 2'd0, 16'h1000, 16'h0000));
    send_item(make_item(CMD_SAMPLE, 12'h001, 2'd0, 16'hF000, 16'h0000));
    send_item(make_item(CMD_SAMPLE, 12'h001, 2'd0, 16'h0FFF, 16'h0000));
    send_item(make_item(CMD_SAMPLE, 12'h001, 2'd0, 16'hEFFF, 16'h0000));
    send_item(make_item(CMD_SAMPLE, 12'h001, 2'd0, 16'h3000, 16'h0000));
    send_item(make_item(CMD_SAMPLE, 12'h001, 2'd0, 16'hD000, 16'h0000));
    send_item(make_item(CMD_LOAD, 12'h001, 2'd0, 16'h2000, 16'h0000));
    send_item(make_item(CMD_SAMPLE, 12'h001, 2'd0, 16'h8000, 16'h0000));
    send_item(make_item(CMD_SAMPLE, 12'h001, 2'd0, 16'h8000, 16'h2000));
  endtask

  task automatic test_random_sweep();
    int unsigned      phase;
    int unsigned      n;
    int unsigned      per_phase;
    logic [CFG_W-1:0] blk;
    logic [2:0]       taps;
    per_phase = RANDOM_ITEMS / SWEEP_PHASES;
    for (phase = 0; phase < SWEEP_PHASES; phase++) begin
      if (phase < SWEEP_PHASES - 1) begin
        blk  = SWEEP_BLK[phase];
        taps = SWEEP_TAPS[phase];
      end else begin
        blk  = CFG_W'($urandom_range(0, 8191));
        taps = 3'($urandom_range(0, 7));
      end
      wait_idle();
      write_cfg(CFG_BLOCK_SIZE, blk);
      write_cfg(CFG_TAPS, {10'd0, taps});
      for (n = 0; n < per_phase; n++) begin
        // Let the result stream run dry once in the middle of a phase.
        if (phase == 5 && n == per_phase / 2) wait_for_results();
        send_item(random_item());
      end
    end
  endtask

  initial begin
    token_pos    = 0;
    blk_setting  = BLK_RESET;
    taps_setting = TAPS_RESET;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_BLOCK_SIZE;
    cfg_wdata       <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.cmd       <= CMD_LOAD;
    in_ch.channel   <= '0;
    in_ch.tap_index <= '0;
    in_ch.value     <= '0;
    in_ch.delta_0   <= '0;
    in_ch.delta_1   <= '0;
    in_ch.delta_2   <= '0;
    in_ch.delta_3   <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_load_coefficients();
    test_prime_history();
    test_corner_values();
    test_rounding();
    test_random_sweep();

    wait_for_results();
    repeat (PIPE_DEPTH * 4) @(posedge clk);
    $display("Covered %0d loads and %0d samples (%0d saturated) with %0d register writes.",
             n_loads, n_samples, n_saturated, n_cfg_writes);
    $display("Deepest block position reached: %0d.", max_pos);
    if (fail_count == 0)
      $display("blocked_causal_dynamic_conv: match");
    else
      $display("blocked_causal_dynamic_conv: mismatch");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/bcdc_pkg.sv
rtl/core/bcdc_in_if.sv
rtl/core/bcdc_out_if.sv
rtl/core/bcdc_store.sv
rtl/core/bcdc_mac.sv
rtl/core/bcdc_round.sv
rtl/core/blocked_causal_dynamic_conv.sv
tb/tb_blocked_causal_dynamic_conv.sv
